// ===== src/sccrc_pkg.sv =====
package sccrc_pkg;

  localparam int unsigned PosWidthDefault = 10;
  localparam int unsigned QueueDepth      = 2;

  localparam logic [9:0]  FrameLengthReset = 10'd518;
  localparam logic [9:0]  FirstOffsetReset = 10'h039;
  localparam logic [15:0] CrcPoly          = 16'h1021;
  localparam logic [15:0] CrcInit          = 16'hFFFF;
  localparam logic [15:0] CrcTop           = 16'h8000;

  typedef enum logic {
    CFG_FRAME_LENGTH = 1'b0,
    CFG_FIRST_OFFSET = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_ID,
    PH_LEN,
    PH_PAYLOAD,
    PH_CRCLO,
    PH_CRCHI,
    PH_HALT
  } phase_e;

  typedef enum logic [2:0] {
    CL_NONE,
    CL_ID,
    CL_LEN,
    CL_PAYLOAD,
    CL_CRCLO,
    CL_CRCHI,
    CL_OVERRUN
  } class_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_first;
  } in_t;

  typedef struct packed {
    logic [7:0]  block_id;
    logic [7:0]  block_len;
    logic [9:0]  block_start;
    logic [15:0] computed_crc;
    logic        crc_ok;
    logic        overrun;
  } out_t;

  typedef struct packed {
    logic [9:0] frame_length;
    logic [9:0] first_block_offset;
  } cfg_t;

  typedef struct packed {
    class_e     cls;
    logic       first;
    logic [7:0] data;
    logic [9:0] pos;
  } item_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcTop) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/sccrc_front.sv =====
module sccrc_front #(
  parameter int unsigned POS_WIDTH = sccrc_pkg::PosWidthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  sccrc_pkg::in_t     in_data_i,
  input  sccrc_pkg::cfg_t    cfg_i,
  output sccrc_pkg::item_t   item_o
);

  localparam int unsigned CmpWidth = (POS_WIDTH > 10) ? POS_WIDTH : 10;
  localparam logic [POS_WIDTH-1:0] PosMax = {POS_WIDTH{1'b1}};

  sccrc_pkg::phase_e phase_q, phase_d, phase_cur;
  logic [POS_WIDTH-1:0] pos_q, pos_d, p;
  logic [9:0]  start_q, start_d;
  logic [7:0]  left_q, left_d, left_dec;
  logic [10:0] end_sum;
  logic        in_frame, ovr, at_offset;

  assign p         = in_data_i.frame_first ? '0 : pos_q;
  assign pos_d     = (p < PosMax) ? p + POS_WIDTH'(1) : PosMax;
  assign in_frame  = CmpWidth'(p) < CmpWidth'(cfg_i.frame_length);
  assign at_offset = CmpWidth'(p) == CmpWidth'(cfg_i.first_block_offset);
  assign end_sum   = 11'(start_q) + 11'(in_data_i.frame_byte) + 11'd4;
  assign ovr       = end_sum > 11'(cfg_i.frame_length);
  assign left_dec  = left_q - 8'd1;

  always_comb begin
    phase_cur = in_data_i.frame_first ? sccrc_pkg::PH_WAIT : phase_q;
    if (phase_cur == sccrc_pkg::PH_WAIT && at_offset) begin
      phase_cur = sccrc_pkg::PH_ID;
    end
  end

  always_comb begin
    phase_d = phase_cur;
    start_d = start_q;
    left_d  = left_q;
    unique case (phase_cur)
      sccrc_pkg::PH_WAIT: ;
      sccrc_pkg::PH_ID: begin
        if (in_frame) begin
          start_d = 10'(p);
          phase_d = sccrc_pkg::PH_LEN;
        end else begin
          phase_d = sccrc_pkg::PH_HALT;
        end
      end
      sccrc_pkg::PH_LEN: begin
        if (ovr) begin
          phase_d = sccrc_pkg::PH_HALT;
        end else begin
          left_d  = in_data_i.frame_byte;
          phase_d = (in_data_i.frame_byte != 8'd0) ? sccrc_pkg::PH_PAYLOAD
                                                   : sccrc_pkg::PH_CRCLO;
        end
      end
      sccrc_pkg::PH_PAYLOAD: begin
        left_d = left_dec;
        if (left_dec == 8'd0) begin
          phase_d = sccrc_pkg::PH_CRCLO;
        end
      end
      sccrc_pkg::PH_CRCLO:  phase_d = sccrc_pkg::PH_CRCHI;
      sccrc_pkg::PH_CRCHI:  phase_d = sccrc_pkg::PH_ID;
      default:              phase_d = sccrc_pkg::PH_HALT;
    endcase
  end

  always_comb begin
    item_o.first = in_data_i.frame_first;
    item_o.data  = in_data_i.frame_byte;
    item_o.pos   = 10'(p);
    unique case (phase_cur)
      sccrc_pkg::PH_ID:      item_o.cls = in_frame ? sccrc_pkg::CL_ID : sccrc_pkg::CL_NONE;
      sccrc_pkg::PH_LEN:     item_o.cls = ovr ? sccrc_pkg::CL_OVERRUN : sccrc_pkg::CL_LEN;
      sccrc_pkg::PH_PAYLOAD: item_o.cls = sccrc_pkg::CL_PAYLOAD;
      sccrc_pkg::PH_CRCLO:   item_o.cls = sccrc_pkg::CL_CRCLO;
      sccrc_pkg::PH_CRCHI:   item_o.cls = sccrc_pkg::CL_CRCHI;
      default:               item_o.cls = sccrc_pkg::CL_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sccrc_pkg::PH_WAIT;
      pos_q   <= '0;
      start_q <= '0;
      left_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      left_q  <= left_d;
    end
  end

endmodule

// ===== src/sccrc_fifo.sv =====
module sccrc_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sccrc_pkg::item_t   push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output sccrc_pkg::item_t   pop_data_o
);

  localparam int unsigned Depth = sccrc_pkg::QueueDepth;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = $clog2(Depth + 1);

  sccrc_pkg::item_t mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] ptr);
    return (ptr == AW'(Depth - 1)) ? '0 : ptr + AW'(1);
  endfunction

  assign full_o     = cnt_q == CW'(Depth);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ptr_inc(wr_q);
      if (pop_i)  rd_q <= ptr_inc(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

// ===== src/sccrc_back.sv =====
module sccrc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  sccrc_pkg::item_t   item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sccrc_pkg::out_t    out_data_o
);

  logic        halted_q, halted_d, live;
  logic [15:0] crc_q, crc_d, crc_next, rx_crc;
  logic [7:0]  id_q, id_d, len_q, len_d, lo_q, lo_d;
  logic [9:0]  start_q, start_d;
  logic        emit, crc_match;
  logic        out_valid_q;
  sccrc_pkg::out_t out_q, out_d;

  assign pop_o     = !empty_i && (!out_valid_q || out_ready_i);
  assign live      = item_i.first || !halted_q;
  assign crc_next  = sccrc_pkg::crc_byte(crc_q, item_i.data);
  assign rx_crc    = {item_i.data, lo_q};
  assign crc_match = rx_crc == crc_q;

  always_comb begin
    halted_d = item_i.first ? 1'b0 : halted_q;
    crc_d    = crc_q;
    id_d     = id_q;
    len_d    = len_q;
    lo_d     = lo_q;
    start_d  = start_q;
    emit     = 1'b0;
    out_d    = out_q;
    if (live) begin
      unique case (item_i.cls)
        sccrc_pkg::CL_ID: begin
          id_d    = item_i.data;
          start_d = item_i.pos;
          crc_d   = sccrc_pkg::CrcInit;
        end
        sccrc_pkg::CL_LEN:     len_d = item_i.data;
        sccrc_pkg::CL_PAYLOAD: crc_d = crc_next;
        sccrc_pkg::CL_CRCLO:   lo_d  = item_i.data;
        sccrc_pkg::CL_CRCHI: begin
          emit     = 1'b1;
          halted_d = !crc_match;
          out_d    = '{block_id: id_q, block_len: len_q, block_start: start_q,
                       computed_crc: crc_q, crc_ok: crc_match, overrun: 1'b0};
        end
        sccrc_pkg::CL_OVERRUN: begin
          emit  = 1'b1;
          len_d = item_i.data;
          out_d = '{block_id: id_q, block_len: item_i.data, block_start: start_q,
                    computed_crc: 16'h0000, crc_ok: 1'b0, overrun: 1'b1};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
      crc_q       <= sccrc_pkg::CrcInit;
      id_q        <= '0;
      len_q       <= '0;
      lo_q        <= '0;
      start_q     <= '0;
    end else begin
      if (pop_o) begin
        halted_q <= halted_d;
        crc_q    <= crc_d;
        id_q     <= id_d;
        len_q    <= len_d;
        lo_q     <= lo_d;
        start_q  <= start_d;
      end
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/subblock_crc16_checker.sv =====
// Output: out_valid_o rises once the back end pops the CRC high byte (or the
//   length byte of an overrun block) from the queue and registers the result.
// Throughput: one frame byte per cycle; the byte-wide CRC update in the back
//   end sets that rate; a two-entry queue absorbs output stalls until full.
// Reset: asynchronous, active low; clears the walk and the position counter,
//   and loads frame_length = 518 and first_block_offset = 57.
module subblock_crc16_checker #(
  parameter int unsigned POS_WIDTH = sccrc_pkg::PosWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sccrc_pkg::in_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sccrc_pkg::out_t   out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [9:0]        cfg_data_i
);

  sccrc_pkg::cfg_t  cfg_q;
  sccrc_pkg::item_t front_item, back_item;
  logic accept, full, empty, pop;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_length       <= sccrc_pkg::FrameLengthReset;
      cfg_q.first_block_offset <= sccrc_pkg::FirstOffsetReset;
    end else if (cfg_we_i) begin
      unique case (sccrc_pkg::cfg_idx_e'(cfg_idx_i))
        sccrc_pkg::CFG_FRAME_LENGTH: cfg_q.frame_length       <= cfg_data_i;
        sccrc_pkg::CFG_FIRST_OFFSET: cfg_q.first_block_offset <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sccrc_front #(
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .item_o    (front_item)
  );

  sccrc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (front_item),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (back_item)
  );

  sccrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (back_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/sccrc_checker.sv =====
module sccrc_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input sccrc_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_overrun_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overrun |->
      out_data_o.computed_crc == 16'h0000 && !out_data_o.crc_ok)
    else $error("overrun result carries a CRC");

  a_ok_not_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.crc_ok |-> !out_data_o.overrun)
    else $error("crc_ok set on overrun result");

  a_backpressure_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> $past(out_valid_o && !out_ready_i))
    else $error("input stalled without an output stall");

endmodule

bind subblock_crc16_checker sccrc_checker u_sccrc_checker (.*);

// ===== verif/crc16_walk_monitor.sv =====
`timescale 1ns / 1ps

package crc16_walk_tb_pkg;

  function automatic logic [15:0] ccitt_update(logic [15:0] acc, logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ sccrc_pkg::CrcPoly;
      end
    end
    return r;
  endfunction

endpackage

module crc16_walk_monitor (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  sccrc_pkg::in_t   in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  sccrc_pkg::out_t  out_data_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [9:0]       cfg_data_i,
  output int unsigned      error_count_o,
  output int unsigned      blocks_pending_o
);

  logic [9:0]        frame_len_q  = sccrc_pkg::FrameLengthReset;
  logic [9:0]        first_off_q  = sccrc_pkg::FirstOffsetReset;
  logic [9:0]        next_pos_q   = '0;
  sccrc_pkg::phase_e walk_q       = sccrc_pkg::PH_WAIT;
  logic [15:0]       crc_q        = sccrc_pkg::CrcInit;
  logic [7:0]        blk_id_q     = '0;
  logic [7:0]        blk_len_q    = '0;
  logic [7:0]        left_q       = '0;
  logic [9:0]        blk_start_q  = '0;
  logic [7:0]        crc_lo_q     = '0;

  sccrc_pkg::out_t   expected_blocks_q[$];
  sccrc_pkg::out_t   want;
  int unsigned       mismatches   = 0;
  int unsigned       pending      = 0;

  assign error_count_o    = mismatches;
  assign blocks_pending_o = pending;

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s expected %0h actual %0h", name, exp_v, got_v);
      mismatches = mismatches + 1;
    end
  endfunction

  function automatic void push_block(logic [15:0] crc, logic ok, logic ovr);
    sccrc_pkg::out_t blk;
    blk.block_id     = blk_id_q;
    blk.block_len    = blk_len_q;
    blk.block_start  = blk_start_q;
    blk.computed_crc = crc;
    blk.crc_ok       = ok;
    blk.overrun      = ovr;
    expected_blocks_q.push_back(blk);
  endfunction

  task automatic walk_byte(input sccrc_pkg::in_t req);
    logic [9:0] p;
    logic       ok;
    p = req.frame_first ? 10'd0 : next_pos_q;
    if (req.frame_first) begin
      walk_q = sccrc_pkg::PH_WAIT;
    end
    if (walk_q == sccrc_pkg::PH_WAIT && p == first_off_q) begin
      walk_q = sccrc_pkg::PH_ID;
    end
    case (walk_q)
      sccrc_pkg::PH_WAIT: begin
      end
      sccrc_pkg::PH_ID: begin
        if (p < frame_len_q) begin
          blk_id_q    = req.frame_byte;
          blk_start_q = p;
          crc_q       = sccrc_pkg::CrcInit;
          walk_q      = sccrc_pkg::PH_LEN;
        end else begin
          walk_q = sccrc_pkg::PH_HALT;
        end
      end
      sccrc_pkg::PH_LEN: begin
        blk_len_q = req.frame_byte;
        if (int'(blk_start_q) + int'(blk_len_q) + 4 > int'(frame_len_q)) begin
          push_block(16'h0000, 1'b0, 1'b1);
          walk_q = sccrc_pkg::PH_HALT;
        end else begin
          left_q = blk_len_q;
          walk_q = (left_q != 0) ? sccrc_pkg::PH_PAYLOAD : sccrc_pkg::PH_CRCLO;
        end
      end
      sccrc_pkg::PH_PAYLOAD: begin
        crc_q  = crc16_walk_tb_pkg::ccitt_update(crc_q, req.frame_byte);
        left_q = left_q - 8'd1;
        if (left_q == 0) begin
          walk_q = sccrc_pkg::PH_CRCLO;
        end
      end
      sccrc_pkg::PH_CRCLO: begin
        crc_lo_q = req.frame_byte;
        walk_q   = sccrc_pkg::PH_CRCHI;
      end
      sccrc_pkg::PH_CRCHI: begin
        ok = ({req.frame_byte, crc_lo_q} == crc_q);
        push_block(crc_q, ok, 1'b0);
        walk_q = ok ? sccrc_pkg::PH_ID : sccrc_pkg::PH_HALT;
      end
      default: begin
        walk_q = sccrc_pkg::PH_HALT;
      end
    endcase
    next_pos_q = (p != 10'h3FF) ? p + 10'd1 : p;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q = sccrc_pkg::FrameLengthReset;
      first_off_q = sccrc_pkg::FirstOffsetReset;
      next_pos_q  = '0;
      walk_q      = sccrc_pkg::PH_WAIT;
      crc_q       = sccrc_pkg::CrcInit;
      blk_id_q    = '0;
      blk_len_q   = '0;
      left_q      = '0;
      blk_start_q = '0;
      crc_lo_q    = '0;
      expected_blocks_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_blocks_q.size() == 0) begin
          $error("block result with none pending: id %0h start %0d",
                 out_data_i.block_id, out_data_i.block_start);
          mismatches = mismatches + 1;
        end else begin
          want = expected_blocks_q.pop_front();
          check_field("block_id", want.block_id, out_data_i.block_id);
          check_field("block_len", want.block_len, out_data_i.block_len);
          check_field("block_start", want.block_start, out_data_i.block_start);
          check_field("computed_crc", want.computed_crc, out_data_i.computed_crc);
          check_field("crc_ok", want.crc_ok, out_data_i.crc_ok);
          check_field("overrun", want.overrun, out_data_i.overrun);
        end
      end
      if (cfg_we_i) begin
        case (sccrc_pkg::cfg_idx_e'(cfg_idx_i))
          sccrc_pkg::CFG_FRAME_LENGTH: frame_len_q = cfg_data_i;
          sccrc_pkg::CFG_FIRST_OFFSET: first_off_q = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        walk_byte(in_data_i);
      end
    end
    pending = expected_blocks_q.size();
  end

endmodule

// ===== verif/tb_subblock_crc16_checker.sv =====
`timescale 1ns / 1ps

module tb_subblock_crc16_checker;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned ByteBudget = 1850;

  logic            clk      = 1'b0;
  logic            rst_n    = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  sccrc_pkg::in_t  in_data  = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  sccrc_pkg::out_t out_data;
  logic            cfg_we   = 1'b0;
  logic            cfg_idx  = sccrc_pkg::CFG_FRAME_LENGTH;
  logic [9:0]      cfg_data = '0;

  int unsigned mismatches;
  int unsigned blocks_pending;

  bit             calm       = 1'b0;
  bit             mark_start = 1'b1;
  int unsigned    idle_pct   = 0;
  int unsigned    sink_pct   = 0;
  int unsigned    stall_left = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    sent       = 0;
  int             frame_base = 0;
  sccrc_pkg::in_t frame_q[$];

  always #2 clk = ~clk;

  subblock_crc16_checker u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  crc16_walk_monitor u_mon (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .error_count_o    (mismatches),
    .blocks_pending_o (blocks_pending)
  );

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (!calm && $urandom_range(99, 0) < sink_pct) begin
      stall_left <= $urandom_range(18, 1);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void add_byte(logic [7:0] b);
    sccrc_pkg::in_t r;
    r.frame_byte  = b;
    r.frame_first = mark_start && (frame_q.size() == frame_base);
    frame_q.push_back(r);
  endfunction

  function automatic void add_block(logic [7:0] id, logic [7:0] len, bit corrupt);
    logic [15:0] c;
    logic [7:0]  d;
    c = sccrc_pkg::CrcInit;
    add_byte(id);
    add_byte(len);
    for (int k = 0; k < int'(len); k++) begin
      d = $urandom;
      c = crc16_walk_tb_pkg::ccitt_update(c, d);
      add_byte(d);
    end
    if (corrupt) begin
      c = c ^ (16'h0001 << $urandom_range(15, 0));
    end
    add_byte(c[7:0]);
    add_byte(c[15:8]);
  endfunction

  function automatic void build_frame(int fl, int off, bit cut, int extra);
    int  pos;
    int  room;
    int  len;
    int  pick;
    bit  ended;
    bit  corrupt;
    frame_base = frame_q.size();
    ended      = 1'b0;
    while (frame_q.size() - frame_base < off && frame_q.size() - frame_base < fl + extra) begin
      add_byte($urandom);
    end
    pos = frame_q.size() - frame_base;
    while (!ended && pos < fl) begin
      room    = fl - pos;
      pick    = $urandom_range(9, 0);
      len     = $urandom_range(12, 0);
      corrupt = 1'b0;
      if (pick == 6 && room >= 4 && room - 4 <= 255) begin
        len = room - 4;
      end else if (pick == 7) begin
        len = room - 3 + $urandom_range(6, 0);
        if (len < 0) len = 0;
        if (len > 255) len = 255;
      end else if (pick >= 8) begin
        corrupt = $urandom_range(1, 0);
      end
      if (pos + len + 4 > fl) begin
        add_byte($urandom);
        add_byte(len[7:0]);
        ended = 1'b1;
      end else begin
        add_block($urandom, len[7:0], corrupt);
        ended = corrupt;
      end
      pos = frame_q.size() - frame_base;
    end
    while (frame_q.size() - frame_base < fl + extra) begin
      add_byte($urandom);
    end
    if (frame_q.size() == frame_base) begin
      add_byte($urandom);
    end
    if (cut) begin
      pos = frame_base + $urandom_range(frame_q.size() - frame_base - 1, 0);
      while (frame_q.size() > pos + 1) begin
        void'(frame_q.pop_back());
      end
    end
  endfunction

  task automatic send_stream();
    sent += frame_q.size();
    for (int k = 0; k < frame_q.size(); k++) begin
      if (!calm && $urandom_range(99, 0) < idle_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(18, 1)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= frame_q[k];
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;
    frame_q.delete();
    frame_base = 0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (blocks_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [9:0] fl, logic [9:0] off);
    cfg_we   <= 1'b1;
    cfg_idx  <= sccrc_pkg::CFG_FRAME_LENGTH;
    cfg_data <= fl;
    @(posedge clk);
    cfg_idx  <= sccrc_pkg::CFG_FIRST_OFFSET;
    cfg_data <= off;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    int fl;
    int off;
    int nframes;
    int extra;
    int phase_no;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, no frame start seen yet
    mark_start = 1'b0;
    build_frame(sccrc_pkg::FrameLengthReset, sccrc_pkg::FirstOffsetReset, 1'b0, 0);
    send_stream();
    mark_start = 1'b1;
    drain();

    write_cfg(10'd24, 10'd1);
    add_byte($urandom);
    add_block(8'hFF, 8'd0, 1'b0);
    add_block(8'h00, 8'd2, 1'b0);
    add_block(8'h5A, 8'd3, 1'b1);
    add_byte($urandom);
    frame_base = frame_q.size();
    add_byte($urandom);
    add_byte(8'h3C);
    add_byte(8'd30);
    frame_base = frame_q.size();
    add_byte($urandom);
    add_byte(8'hC3);
    add_byte(8'd4);
    add_byte($urandom);
    add_byte($urandom);
    send_stream();
    drain();

    phase_no = 0;
    while (sent < ByteBudget) begin
      nframes = $urandom_range(6, 2);
      extra   = $urandom_range(3, 0);
      case (phase_no)
        0: begin fl = 0;    off = 0;    nframes = 3; end
        1: begin fl = 1023; off = 990;  nframes = 1; extra = 12; end
        2: begin fl = 0;    off = 1023; nframes = 2; end
        3: begin fl = 260;  off = 0;    nframes = 1; end
        default: begin
          fl  = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 100)
                                            : $urandom_range(80, 4);
          off = ($urandom_range(7, 0) == 0) ? fl + $urandom_range(3, 0)
                                            : $urandom_range(fl / 3, 0);
        end
      endcase
      idle_pct = ($urandom_range(2, 0) == 0) ? 0 : (($urandom_range(1, 0) == 0) ? 5 : 30);
      sink_pct = ($urandom_range(2, 0) == 0) ? 0 : (($urandom_range(1, 0) == 0) ? 5 : 30);
      calm     = (sent > ByteBudget - 200);
      write_cfg(fl[9:0], off[9:0]);
      for (int f = 0; f < nframes && sent + frame_q.size() < ByteBudget; f++) begin
        build_frame(fl, off, (phase_no == 3) || ($urandom_range(4, 0) == 0), extra);
      end
      send_stream();
      drain();
      phase_no++;
    end

    if (mismatches == 0 && blocks_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== subblock_crc16_checker.f =====
src/sccrc_pkg.sv
src/sccrc_front.sv
src/sccrc_fifo.sv
src/sccrc_back.sv
src/subblock_crc16_checker.sv
src/sccrc_checker.sv
verif/crc16_walk_monitor.sv
verif/tb_subblock_crc16_checker.sv
